/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the asynchronous reset is held.
`define SVPWM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that holds at every edge, reset included.
`define SVPWM_ASSERT(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/svpwm_pkg.sv */
// Shared types and constants of the servo pulse width monitor.
package svpwm_pkg;

	// Field widths of the stream items.
	localparam int unsigned TIME_W    = 16;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned IN_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 24;

	// Bit positions inside the result tdata.
	localparam int unsigned OUT_OK_BIT  = 16;
	localparam int unsigned OUT_ACC_BIT = 17;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_WIDTH_MIN     = 2'd0;
	localparam cfg_idx_t REG_WIDTH_MAX     = 2'd1;
	localparam cfg_idx_t REG_INVALID_LIMIT = 2'd2;

	// Register reset values.
	localparam logic [TIME_W-1:0]  WIDTH_MIN_RST     = 16'd1000;
	localparam logic [TIME_W-1:0]  WIDTH_MAX_RST     = 16'd2000;
	localparam logic [COUNT_W-1:0] INVALID_LIMIT_RST = 8'd10;

	// Penalty added to the invalid count when a pulse goes missing.
	localparam logic [COUNT_W-1:0] OVERFLOW_PENALTY = 8'd3;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'd255;

	// Input event kinds carried in tuser.
	localparam logic MODE_EDGE     = 1'b0;
	localparam logic MODE_OVERFLOW = 1'b1;

endpackage

/* hw/rtl/servo_pulse_width_monitor.sv */
// Servo pulse width monitor: edge timestamps in, width average and signal status out.
// The result of each transaction is registered in the output register.
// Throughput: one transaction per cycle while the output register is empty or m_tready is high;
// the ring entry to be replaced is prefetched from the synchronous ring memory.
// Reset: asynchronous, active low; clears control state, ring valid bits and the
// fill value, so every ring entry reads as zero until written. No clearing pass.
module servo_pulse_width_monitor #(
	parameter int unsigned AVG_DEPTH_LOG2 = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [svpwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Event stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [svpwm_pkg::IN_DATA_W-1:0]     s_tdata,  // [15:0] capture_time
	input  logic                                s_tuser,  // [0] mode
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] average_width, [16] signal_ok, [17] width_accepted, [23:18] zero
	output logic [svpwm_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int unsigned DEPTH = 1 << AVG_DEPTH_LOG2;
	localparam int unsigned SUM_W = svpwm_pkg::TIME_W + AVG_DEPTH_LOG2;
	localparam logic [AVG_DEPTH_LOG2-1:0] PTR_ONE = AVG_DEPTH_LOG2'(1);

	typedef logic [svpwm_pkg::TIME_W-1:0]  time_t;
	typedef logic [svpwm_pkg::COUNT_W-1:0] count_t;
	typedef logic [AVG_DEPTH_LOG2-1:0]     ptr_t;
	typedef logic [SUM_W-1:0]              sum_t;

	// Configuration registers.
	time_t  width_min_q;
	time_t  width_max_q;
	count_t invalid_limit_q;

	// Scalar state.
	ptr_t   ptr_q;
	sum_t   sum_q;
	time_t  rise_q;
	logic   expect_fall_q;
	logic   ovf_pending_q;
	count_t bad_count_q;
	logic   error_q;
	time_t  fill_q;
	logic [DEPTH-1:0] ring_valid_q;

	// Ring memory and its registered read port.
	time_t ring_mem [DEPTH];
	time_t ring_rd_q;

	// Output register.
	logic                              out_valid_q;
	logic [svpwm_pkg::OUT_DATA_W-1:0]  out_data_q;

	// Next-state signals.
	logic   in_fire;
	ptr_t   ptr_d;
	sum_t   sum_d;
	time_t  rise_d;
	logic   expect_fall_d;
	logic   ovf_pending_d;
	count_t bad_count_d;
	logic   error_d;
	time_t  fill_d;
	logic   ring_add;
	logic   ring_fill;
	logic   accepted;
	time_t  width;
	time_t  old_entry;
	logic   width_ok;
	logic [svpwm_pkg::COUNT_W:0] penalty_sum;
	count_t bad_inc;
	count_t bad_dec;
	count_t bad_pen;
	time_t  capture_time;

	assign capture_time = s_tdata[svpwm_pkg::TIME_W-1:0];
	assign s_tready     = !out_valid_q || m_tready;
	assign in_fire      = s_tvalid && s_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

	// Entry about to be replaced: an entry not written since the last refill reads as the fill value.
	assign old_entry = ring_valid_q[ptr_q] ? ring_rd_q : fill_q;

	// Pulse width by wrapping subtraction and the limit check.
	assign width    = capture_time - rise_q;
	assign width_ok = (width >= width_min_q) && (width <= width_max_q);

	// Saturating count updates.
	assign penalty_sum = {1'b0, bad_count_q} + {1'b0, svpwm_pkg::OVERFLOW_PENALTY};
	assign bad_inc     = (bad_count_q == svpwm_pkg::COUNT_MAX) ? svpwm_pkg::COUNT_MAX
	                                                           : bad_count_q + count_t'(1);
	assign bad_dec     = (bad_count_q == '0) ? '0 : bad_count_q - count_t'(1);
	assign bad_pen     = penalty_sum[svpwm_pkg::COUNT_W] ? svpwm_pkg::COUNT_MAX
	                                                     : penalty_sum[svpwm_pkg::COUNT_W-1:0];

	// Event processing for one accepted transaction.
	always_comb begin
		ptr_d         = ptr_q;
		sum_d         = sum_q;
		rise_d        = rise_q;
		expect_fall_d = expect_fall_q;
		ovf_pending_d = ovf_pending_q;
		bad_count_d   = bad_count_q;
		error_d       = error_q;
		fill_d        = fill_q;
		ring_add      = 1'b0;
		ring_fill     = 1'b0;
		accepted      = 1'b0;
		if (in_fire) begin
			if (s_tuser == svpwm_pkg::MODE_EDGE) begin
				if (!expect_fall_q) begin
					rise_d        = capture_time;
					expect_fall_d = 1'b1;
				end else begin
					expect_fall_d = 1'b0;
					ovf_pending_d = 1'b0;
					if (!width_ok) begin
						if (!error_q) begin
							bad_count_d = bad_inc;
							error_d     = (bad_inc > invalid_limit_q);
						end
					end else begin
						accepted = 1'b1;
						if (error_q) begin
							bad_count_d = bad_dec;
							if (bad_dec == '0) begin
								error_d   = 1'b0;
								ring_fill = 1'b1;
							end
						end else begin
							ring_add = 1'b1;
						end
					end
				end
			end else begin
				if (ovf_pending_q) begin
					expect_fall_d = 1'b0;
					ovf_pending_d = 1'b0;
					rise_d        = '0;
					if (!error_q) begin
						bad_count_d = bad_pen;
						error_d     = (bad_pen >= invalid_limit_q);
					end
				end else begin
					ovf_pending_d = 1'b1;
				end
			end
		end
		// Ring bookkeeping: a refill resets the sum and pointer, an add replaces one entry.
		if (ring_fill) begin
			fill_d = width;
			sum_d  = {width, {AVG_DEPTH_LOG2{1'b0}}};
			ptr_d  = '0;
		end else if (ring_add) begin
			sum_d = sum_q - {{AVG_DEPTH_LOG2{1'b0}}, old_entry}
			              + {{AVG_DEPTH_LOG2{1'b0}}, width};
			ptr_d = ptr_q + PTR_ONE;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_min_q     <= svpwm_pkg::WIDTH_MIN_RST;
			width_max_q     <= svpwm_pkg::WIDTH_MAX_RST;
			invalid_limit_q <= svpwm_pkg::INVALID_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svpwm_pkg::REG_WIDTH_MIN:     width_min_q     <= cfg_data;
				svpwm_pkg::REG_WIDTH_MAX:     width_max_q     <= cfg_data;
				svpwm_pkg::REG_INVALID_LIMIT: invalid_limit_q <= cfg_data[svpwm_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Scalar state and ring valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			sum_q         <= '0;
			rise_q        <= '0;
			expect_fall_q <= 1'b0;
			ovf_pending_q <= 1'b0;
			bad_count_q   <= '0;
			error_q       <= 1'b0;
			fill_q        <= '0;
			ring_valid_q  <= '0;
		end else begin
			ptr_q         <= ptr_d;
			sum_q         <= sum_d;
			rise_q        <= rise_d;
			expect_fall_q <= expect_fall_d;
			ovf_pending_q <= ovf_pending_d;
			bad_count_q   <= bad_count_d;
			error_q       <= error_d;
			fill_q        <= fill_d;
			if (ring_fill) begin
				ring_valid_q <= '0;
			end else if (ring_add) begin
				ring_valid_q[ptr_q] <= 1'b1;
			end
		end
	end

	// Ring memory: write the new width, prefetch the entry the pointer will reach next.
	always_ff @(posedge clk) begin
		if (ring_add) begin
			ring_mem[ptr_q] <= width;
		end
		ring_rd_q <= ring_mem[ptr_d];
	end

	// Output register, emptied when the transaction is taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields packed from the lowest bit up, spare bits zero.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= {{(svpwm_pkg::OUT_DATA_W-svpwm_pkg::OUT_ACC_BIT-1){1'b0}},
			               accepted, !error_d,
			               error_d ? time_t'('0) : sum_d[SUM_W-1:AVG_DEPTH_LOG2]};
		end
	end

endmodule

/* hw/rtl/svpwm_checker.sv */
// Port-level checker for the servo pulse width monitor and its bind.
`include "assert_macros.svh"

module svpwm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [svpwm_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// A stalled result holds its value.
	`SVPWM_ASSERT_RST(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	// An empty output register never back-pressures the input.
	`SVPWM_ASSERT_RST(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready, "input stalled with empty output")

	// Every input transaction yields a result in the next cycle.
	`SVPWM_ASSERT_RST(a_result_follows, clk, arst_n, s_tvalid && s_tready |=> m_tvalid, "result missing after transaction")

	// In signal error the average reads zero.
	`SVPWM_ASSERT_RST(a_err_avg_zero, clk, arst_n, m_tvalid && !m_tdata[svpwm_pkg::OUT_OK_BIT] |-> m_tdata[svpwm_pkg::TIME_W-1:0] == '0, "average not zero in error")

	// An overflow tick never completes a pulse.
	`SVPWM_ASSERT_RST(a_ovf_no_accept, clk, arst_n, s_tvalid && s_tready && (s_tuser == svpwm_pkg::MODE_OVERFLOW) |=> !m_tdata[svpwm_pkg::OUT_ACC_BIT], "overflow marked as accepted width")

endmodule

bind servo_pulse_width_monitor svpwm_checker u_svpwm_checker (.*);
